/* design/oiw_pkg.sv */
// ----------------------------------------------------------------------------
// oiw_pkg
// Shared constants and controller/datapath interface types for the
// order-isomorphic window matcher.
// ----------------------------------------------------------------------------
package oiw_pkg;

  localparam int unsigned WINDOW_DEFAULT      = 7;
  localparam int unsigned VALUE_WIDTH_DEFAULT = 16;

  // Configuration register map: pattern values first, then the limit.
  localparam int unsigned CFG_INDEX_W  = 3;
  localparam int unsigned LIMIT_W      = 3;
  localparam int unsigned POS_W        = 32;
  localparam logic [CFG_INDEX_W-1:0] LIMIT_INDEX = 3'd7;
  localparam logic [LIMIT_W-1:0]     LIMIT_RESET = 3'd2;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_BUILD = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic shift;     // take the accepted text value into the window
    logic build;     // register the pairwise disagreement matrix, clear the mask
    logic scan_inc;  // step to the next ignore mask
    logic load_out;  // move the start position into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;       // window holds a complete set of values
    logic hit;        // current ignore mask gives a match
    logic scan_last;  // current ignore mask is the last one to try
    logic out_free;   // output register can take a result this cycle
  } status_t;

endpackage

/* design/oiw_ctrl.sv */
// ----------------------------------------------------------------------------
// oiw_ctrl
// Controller: accepts one text value, orders the compare-matrix build,
// steps the ignore-mask scan and hands a match to the output register.
// ----------------------------------------------------------------------------
module oiw_ctrl
  import oiw_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_axis_tvalid,
  output logic    s_axis_tready,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.shift = 1'b1;
          state_d     = ST_BUILD;
        end
      end
      ST_BUILD: begin
        cmd_o.build = 1'b1;
        state_d     = status_i.full ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if (status_i.hit) begin
          state_d = ST_EMIT;
        end else if (status_i.scan_last) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_accept_to_build : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && s_axis_tvalid) |=> (state_q == ST_BUILD))
    else $error("accepted transaction did not start a matrix build");

  a_hit_to_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && status_i.hit) |=> (state_q == ST_EMIT))
    else $error("match found but result not scheduled");

  a_emit_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && !status_i.out_free) |=> (state_q == ST_EMIT))
    else $error("pending result dropped while output register busy");

endmodule

/* design/oiw_dp.sv */
// ----------------------------------------------------------------------------
// oiw_dp
// Datapath: pattern and limit registers, text window shift line, position
// counter, registered pairwise disagreement matrix, ignore-mask counter
// and output register.
// ----------------------------------------------------------------------------
module oiw_dp
  import oiw_pkg::*;
#(
  parameter int unsigned WINDOW      = WINDOW_DEFAULT,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [VALUE_WIDTH-1:0] cfg_data_i,
  input  logic [VALUE_WIDTH-1:0] text_value_i,
  input  cmd_t                   cmd_i,
  output status_t                status_o,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [POS_W-1:0]       m_axis_tdata
);

  localparam int unsigned FILL_W = $clog2(WINDOW + 1);
  localparam logic [WINDOW-1:0] MASK_LAST = ~WINDOW'(1);

  logic signed [VALUE_WIDTH-1:0] pattern_q [WINDOW];
  logic signed [VALUE_WIDTH-1:0] window_q  [WINDOW];
  logic [LIMIT_W-1:0]            limit_q;
  logic [FILL_W-1:0]             fill_q;
  logic [POS_W-1:0]              pos_q;
  logic [POS_W-1:0]              start_q;
  logic [WINDOW-1:0]             bad_q [WINDOW];
  logic [WINDOW-1:0]             bad_d [WINDOW];
  logic [WINDOW-1:0]             mask_q;
  logic                          out_valid_q;
  logic [POS_W-1:0]              out_data_q;
  logic                          keep_ok;
  logic [LIMIT_W-1:0]            mask_ones;
  logic                          full;

  // Configuration registers. Pattern entries beyond the window are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) begin
        pattern_q[i] <= '0;
      end
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i) begin
      for (int i = 0; i < WINDOW; i++) begin
        if (cfg_index_i == CFG_INDEX_W'(i)) begin
          pattern_q[i] <= cfg_data_i;
        end
      end
      if (cfg_index_i == LIMIT_INDEX) begin
        limit_q <= cfg_data_i[LIMIT_W-1:0];
      end
    end
  end

  // Window shift line: offset 0 holds the oldest value.
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      for (int i = 0; i < WINDOW - 1; i++) begin
        window_q[i] <= window_q[i+1];
      end
      window_q[WINDOW-1] <= text_value_i;
    end
  end

  assign full = (fill_q == FILL_W'(WINDOW));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      pos_q  <= '0;
    end else if (cmd_i.shift) begin
      if (!full) begin
        fill_q <= fill_q + FILL_W'(1);
      end
      pos_q <= pos_q + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      start_q <= pos_q - POS_W'(WINDOW - 1);
    end
  end

  // A pair disagrees when the pattern order and the window order differ.
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      for (int j = 0; j < WINDOW; j++) begin
        bad_d[i][j] = (pattern_q[i] <= pattern_q[j]) != (window_q[i] <= window_q[j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.build) begin
      for (int i = 0; i < WINDOW; i++) begin
        bad_q[i] <= bad_d[i];
      end
      mask_q <= '0;
    end else if (cmd_i.scan_inc) begin
      mask_q <= mask_q + WINDOW'(1);
    end
  end

  // Test the current ignore mask against the stored matrix.
  always_comb begin
    keep_ok   = 1'b1;
    mask_ones = '0;
    for (int i = 0; i < WINDOW; i++) begin
      for (int j = 0; j < WINDOW; j++) begin
        if (bad_q[i][j] && !mask_q[i] && !mask_q[j]) begin
          keep_ok = 1'b0;
        end
      end
    end
    for (int i = 0; i < WINDOW; i++) begin
      mask_ones = mask_ones + LIMIT_W'(mask_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= start_q;
    end
  end

  assign status_o.full      = full;
  assign status_o.hit       = keep_ok && ((mask_q == '0) || (mask_ones == limit_q));
  assign status_o.scan_last = (mask_q == MASK_LAST);
  assign status_o.out_free  = !out_valid_q || m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_load_only_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || m_axis_tready))
    else $error("output register overwritten before its transaction");

  a_load_sets_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=> out_valid_q)
    else $error("loaded result not presented");

  a_scan_needs_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_inc |-> full)
    else $error("mask scan running on a partial window");

endmodule

/* design/order_isomorphic_window_k_mismatch.sv */
// ----------------------------------------------------------------------------
// order_isomorphic_window_k_mismatch
// Sliding-window order-isomorphic matcher that tolerates a configured number
// of ignored positions; emits the window start position on a match.
// ----------------------------------------------------------------------------
// Operation: a match appears on m_axis after the compare matrix is registered, the
//   ignore masks are scanned in turn and the start position is loaded out.
// Flow: a new text value is taken only once the previous one has finished its
//   build, scan and output load; output stalls also hold off input.
// Reset: asynchronous, active low; clears window fill, position counter, output valid,
//   pattern registers (to 0), the mismatch limit (to 2) and sets the controller idle.
module order_isomorphic_window_k_mismatch
  import oiw_pkg::*;
#(
  parameter  int unsigned WINDOW      = WINDOW_DEFAULT,
  parameter  int unsigned VALUE_WIDTH = VALUE_WIDTH_DEFAULT,
  localparam int unsigned TDATA_W     = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [VALUE_WIDTH-1:0] cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [TDATA_W-1:0]     s_axis_tdata,   // text_value
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [POS_W-1:0]       m_axis_tdata    // window_start
);

  cmd_t    cmd;
  status_t status;

  // Registers may be written at any time the port is driven.
  assign cfg_ready_o = 1'b1;

  oiw_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  oiw_dp #(
    .WINDOW      (WINDOW),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .text_value_i  (s_axis_tdata[VALUE_WIDTH-1:0]),
    .cmd_i         (cmd),
    .status_o      (status),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
